/* src/mrfe_pkg.sv */
package mrfe_pkg;

    localparam logic [1:0] OP_READ   = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_RECV   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic KIND_TX    = 1'b0;
    localparam logic KIND_CHECK = 1'b1;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_HEADER = 2'd1;
    localparam logic [1:0] STATUS_CRC    = 2'd2;

    localparam logic [7:0]  FUNC_READ        = 8'h03;
    localparam logic [7:0]  FUNC_WRITE       = 8'h06;
    localparam logic [7:0]  REPLY_BYTE_COUNT = 8'h02;
    localparam logic [15:0] CRC_INIT         = 16'hFFFF;
    localparam logic [15:0] CRC_POLY         = 16'hA001;

    localparam logic [7:0] SLAVE_ADDR_RESET = 8'h01;
    localparam logic [1:0] ADDR_SLAVE       = 2'd0;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } tx_beat_t;

    typedef struct packed {
        logic        valid;
        logic [1:0]  status;
        logic [15:0] value;
    } rx_result_t;

    // one byte through the reflected crc-16, bit by bit
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

/* src/modbus_rtu_master_frame_engine_core.sv */
// request: first frame byte is out in the cycle after accept, eight bytes in all,
// next item not accepted before the last byte is passed on (the serializer sends one
// byte per cycle while the output slot is free; all but the crc bytes feed the crc)
// reply byte: one item per cycle while in_ready is high, check result registered to
// the output in the cycle after the seventh byte; reset (async, active low): slave
// address 1, receiver cleared, serializer idle, output empty
module modbus_rtu_master_frame_engine_core
    import mrfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [15:0] register_address,
    input  logic [15:0] word_value,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [7:0]  tx_byte,
    output logic        last,
    output logic [1:0]  status,
    output logic [15:0] register_value
);

    logic [7:0]  slave_reg;
    logic        out_valid_reg;
    logic        kind_reg;
    logic [7:0]  tx_byte_reg;
    logic        last_reg;
    logic [1:0]  status_reg;
    logic [15:0] value_reg;
    logic        slot_free;
    logic        in_take;
    logic        req_take;
    logic        rx_take;
    logic        tx_busy;
    tx_beat_t    tx_beat;
    rx_result_t  rx_result;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_SLAVE) ? {24'h000000, slave_reg} : 32'h00000000;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_reg <= SLAVE_ADDR_RESET;
        end
        else if (psel && penable && pwrite && (paddr == ADDR_SLAVE))
        begin
            slave_reg <= pwdata[7:0];
        end
    end

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = !tx_busy && slot_free;
    assign in_take   = in_valid && in_ready;
    assign req_take  = in_take && ((op == OP_READ) || (op == OP_WRITE));
    assign rx_take   = in_take && (op == OP_RECV);

    mrfe_tx u_tx (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (req_take),
        .op               (op),
        .slave_address    (slave_reg),
        .register_address (register_address),
        .word_value       (word_value),
        .slot_free        (slot_free),
        .busy             (tx_busy),
        .beat             (tx_beat)
    );

    mrfe_rx u_rx (
        .clk           (clk),
        .rst_n         (rst_n),
        .clear         (req_take),
        .take          (rx_take),
        .rx_byte       (rx_byte),
        .slave_address (slave_reg),
        .result        (rx_result)
    );

    // the three beat sources never fire together: in_ready is low while serializing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((tx_beat.valid && slot_free) || req_take || rx_result.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tx_beat.valid && slot_free)
        begin
            kind_reg    <= KIND_TX;
            tx_byte_reg <= tx_beat.data;
            last_reg    <= tx_beat.last;
            status_reg  <= STATUS_OK;
            value_reg   <= 16'h0000;
        end
        else if (req_take)
        begin
            kind_reg    <= KIND_TX;
            tx_byte_reg <= slave_reg;
            last_reg    <= 1'b0;
            status_reg  <= STATUS_OK;
            value_reg   <= 16'h0000;
        end
        else if (rx_result.valid)
        begin
            kind_reg    <= KIND_CHECK;
            tx_byte_reg <= 8'h00;
            last_reg    <= 1'b1;
            status_reg  <= rx_result.status;
            value_reg   <= rx_result.value;
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign tx_byte        = tx_byte_reg;
    assign last           = last_reg;
    assign status         = status_reg;
    assign register_value = value_reg;

`ifndef SYNTHESIS
    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        tx_busy |-> !in_ready)
        else $error("input taken while frame is serializing");

    a_request_starts_frame: assert property (@(posedge clk) disable iff (!rst_n)
        req_take |=> (out_valid && tx_busy && (kind == KIND_TX) && !last))
        else $error("request did not start a frame");

    a_check_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind == KIND_CHECK)) |-> last)
        else $error("check result without last");

    a_failed_check_no_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != STATUS_OK)) |-> (register_value == 16'h0000))
        else $error("failed check carries a value");

    a_tx_beat_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind == KIND_TX)) |->
            ((status == STATUS_OK) && (register_value == 16'h0000)))
        else $error("transmit beat carries check fields");
`endif

endmodule

/* src/mrfe_tx.sv */
module mrfe_tx
    import mrfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [1:0]  op,
    input  logic [7:0]  slave_address,
    input  logic [15:0] register_address,
    input  logic [15:0] word_value,
    input  logic        slot_free,
    output logic        busy,
    output tx_beat_t    beat
);

    logic        busy_reg, busy_next;
    logic [2:0]  idx_reg, idx_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  func_reg, func_next;
    logic [15:0] reg_addr_reg, reg_addr_next;
    logic [15:0] word_reg, word_next;
    logic [7:0]  cur_byte;
    logic        advance;

    // byte 0 (slave address) is sent by the top level at start
    always_comb
    begin
        case (idx_reg)
            3'd1:    cur_byte = func_reg;
            3'd2:    cur_byte = reg_addr_reg[15:8];
            3'd3:    cur_byte = reg_addr_reg[7:0];
            3'd4:    cur_byte = word_reg[15:8];
            3'd5:    cur_byte = word_reg[7:0];
            3'd6:    cur_byte = crc_reg[7:0];
            3'd7:    cur_byte = crc_reg[15:8];
            default: cur_byte = 8'h00;
        endcase
    end

    assign advance = busy_reg && slot_free;

    always_comb
    begin
        busy_next     = busy_reg;
        idx_next      = idx_reg;
        crc_next      = crc_reg;
        func_next     = func_reg;
        reg_addr_next = reg_addr_reg;
        word_next     = word_reg;
        if (start)
        begin
            busy_next     = 1'b1;
            idx_next      = 3'd1;
            crc_next      = crc_feed(CRC_INIT, slave_address);
            func_next     = (op == OP_WRITE) ? FUNC_WRITE : FUNC_READ;
            reg_addr_next = register_address;
            word_next     = word_value;
        end
        else if (advance)
        begin
            if (idx_reg <= 3'd5)
            begin
                crc_next = crc_feed(crc_reg, cur_byte);
            end
            if (idx_reg == 3'd7)
            begin
                busy_next = 1'b0;
            end
            idx_next = idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        crc_reg      <= crc_next;
        func_reg     <= func_next;
        reg_addr_reg <= reg_addr_next;
        word_reg     <= word_next;
    end

    assign busy       = busy_reg;
    assign beat.valid = busy_reg;
    assign beat.data  = cur_byte;
    assign beat.last  = (idx_reg == 3'd7);

endmodule

/* src/mrfe_rx.sv */
module mrfe_rx
    import mrfe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       clear,
    input  logic       take,
    input  logic [7:0] rx_byte,
    input  logic [7:0] slave_address,
    output rx_result_t result
);

    localparam logic [2:0] POS_ADDR    = 3'd0;
    localparam logic [2:0] POS_FUNC    = 3'd1;
    localparam logic [2:0] POS_COUNT   = 3'd2;
    localparam logic [2:0] POS_DATA_HI = 3'd3;
    localparam logic [2:0] POS_DATA_LO = 3'd4;
    localparam logic [2:0] POS_CRC_LO  = 3'd5;
    localparam logic [2:0] POS_CRC_HI  = 3'd6;

    logic [2:0]  pos_reg, pos_next;
    logic [15:0] crc_reg, crc_next;
    logic        hdr_good_reg, hdr_good_next;
    logic [15:0] data_reg, data_next;
    logic [7:0]  crc_lo_reg, crc_lo_next;
    logic        done;

    assign done = take && (pos_reg == POS_CRC_HI);

    always_comb
    begin
        pos_next      = pos_reg;
        crc_next      = crc_reg;
        hdr_good_next = hdr_good_reg;
        data_next     = data_reg;
        crc_lo_next   = crc_lo_reg;
        if (clear || done)
        begin
            pos_next      = POS_ADDR;
            crc_next      = CRC_INIT;
            hdr_good_next = 1'b1;
            data_next     = 16'h0000;
            crc_lo_next   = 8'h00;
        end
        else if (take)
        begin
            case (pos_reg)
                POS_ADDR:
                begin
                    if (rx_byte != slave_address)
                    begin
                        hdr_good_next = 1'b0;
                    end
                end
                POS_FUNC:
                begin
                    if (rx_byte != FUNC_READ)
                    begin
                        hdr_good_next = 1'b0;
                    end
                end
                POS_COUNT:
                begin
                    if (rx_byte != REPLY_BYTE_COUNT)
                    begin
                        hdr_good_next = 1'b0;
                    end
                end
                POS_DATA_HI: data_next = {rx_byte, data_reg[7:0]};
                POS_DATA_LO: data_next = {data_reg[15:8], rx_byte};
                POS_CRC_LO:  crc_lo_next = rx_byte;
                default:     crc_lo_next = crc_lo_reg;
            endcase
            if (pos_reg < POS_CRC_LO)
            begin
                crc_next = crc_feed(crc_reg, rx_byte);
            end
            pos_next = pos_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= POS_ADDR;
            crc_reg      <= CRC_INIT;
            hdr_good_reg <= 1'b1;
            data_reg     <= 16'h0000;
            crc_lo_reg   <= 8'h00;
        end
        else
        begin
            pos_reg      <= pos_next;
            crc_reg      <= crc_next;
            hdr_good_reg <= hdr_good_next;
            data_reg     <= data_next;
            crc_lo_reg   <= crc_lo_next;
        end
    end

    always_comb
    begin
        result.valid  = done;
        result.status = STATUS_OK;
        result.value  = 16'h0000;
        if (!hdr_good_reg)
        begin
            result.status = STATUS_HEADER;
        end
        else if ({rx_byte, crc_lo_reg} != crc_reg)
        begin
            result.status = STATUS_CRC;
        end
        else
        begin
            result.value = data_reg;
        end
    end

endmodule
